// File: rtl/conflict_graph_slot_coloring_assert.svh
// Assertion macros for the slot coloring block.
// Used by conflict_graph_slot_coloring.sv; needs nothing else.
`ifndef CONFLICT_GRAPH_SLOT_COLORING_ASSERT_SVH
`define CONFLICT_GRAPH_SLOT_COLORING_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CGSC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CGSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cgsc_pkg.sv
// Shared constants and types for the conflict graph slot coloring block.
// No dependencies; imported by conflict_graph_slot_coloring.
package cgsc_pkg;

    localparam int NUM_SUBJECTS_DEF = 16;
    localparam int MAX_OUT          = 16;
    localparam int CODE_W           = 4;
    localparam int SLOT_W           = 5;
    localparam int CNT_W            = 6;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SCHED = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_LOAD,
        S_SCAN,
        S_PICK,
        S_EMIT
    } t_state;

endpackage

// File: rtl/cgsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module cgsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/conflict_graph_slot_coloring.sv
// Top level of the conflict graph slot coloring block.
// Depends on cgsc_pkg, cgsc_ram and conflict_graph_slot_coloring_assert.svh.
//
// Usage:
//   Command channel: a beat is taken when start is high and busy is low.
//   i_command = add takes an enrollment of three subject codes and marks each
//   distinct pair as conflicting; busy stays low, so records can stream in
//   one per cycle. i_command = schedule raises busy and runs a search for the
//   fewest slots (1, 2, ...), coloring subjects in index order with lowest
//   slot first and real backtracking.
//   Result channel: one beat per reported subject (the first min(NUM_SUBJECTS,16)),
//   subject 0 upward, each on the o_ ports for exactly one cycle while o_valid is
//   high; o_last flags the final subject. The receiver cannot stall, so beats
//   leave at one per cycle. A schedule zeroes the slot RAM, then at every search
//   step at position k scans the slots below k through the single read port and
//   tries slots one by one in the shared compare step, then emits the result
//   beats. The run time is data dependent and set by how much backtracking the
//   graph forces.
//   Reset clears the conflict matrix and the sequencer; the slot RAM is not
//   reset because each schedule zeroes it before use.
`include "conflict_graph_slot_coloring_assert.svh"

module conflict_graph_slot_coloring #(
    parameter int NUM_SUBJECTS = cgsc_pkg::NUM_SUBJECTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [cgsc_pkg::CODE_W-1:0] i_subject_a,
    input  logic [cgsc_pkg::CODE_W-1:0] i_subject_b,
    input  logic [cgsc_pkg::CODE_W-1:0] i_subject_c,
    output logic                        o_valid,
    output logic [cgsc_pkg::CODE_W-1:0] o_subject,
    output logic [cgsc_pkg::SLOT_W-1:0] o_slot,
    output logic [cgsc_pkg::SLOT_W-1:0] o_slot_count,
    output logic                        o_last
);
    import cgsc_pkg::*;

    // Subjects that can carry conflicts and that are reported.
    localparam int OUT   = (NUM_SUBJECTS < MAX_OUT) ? NUM_SUBJECTS : MAX_OUT;
    localparam int IDX_W = $clog2(NUM_SUBJECTS);
    localparam int K_W   = $clog2(NUM_SUBJECTS + 1);

    // Sequencer state
    t_state             r_state, n_state;
    logic [OUT-1:0]     r_matrix [OUT];
    logic [OUT-1:0]     n_matrix [OUT];
    logic [K_W-1:0]     r_k, n_k;          // search position
    logic [K_W-1:0]     r_i, n_i;          // sweep / scan / emit counter
    logic [CNT_W-1:0]   r_limit, n_limit;  // slot count under trial
    logic               r_pv, n_pv;        // a RAM read is returning now
    // Datapath holding registers
    logic               r_pcur, n_pcur;    // returning read is slot of position k
    logic [IDX_W-1:0]   r_pidx, n_pidx;
    logic [CNT_W-1:0]   r_c, n_c;          // slot candidate
    logic [SLOT_W-1:0]  r_hi, n_hi;        // largest slot below position k
    logic [NUM_SUBJECTS-1:0] r_mask, n_mask; // slots taken by conflicting subjects

    // RAM port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [SLOT_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [SLOT_W-1:0]  ram_rdata;

    // Shared compare step
    logic               accept;
    logic [OUT-1:0]     cur_row;
    logic               row_bit;
    logic [CNT_W-1:0]   hi_p1;
    logic [CNT_W-1:0]   cap;
    logic               used;
    logic               over_cap;

    function automatic logic pair_hit(int j, int q,
                                      logic [CODE_W-1:0] p0, logic [CODE_W-1:0] p1);
        logic hit;
        hit = (p0 != p1) &&
              ((int'(p0) == j && int'(p1) == q) || (int'(p1) == j && int'(p0) == q));
        return hit;
    endfunction

    cgsc_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_SUBJECTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Row of position k and the conflict bit of the returning subject
    always_comb begin
        cur_row = '0;
        row_bit = 1'b0;
        for (int j = 0; j < OUT; j++) begin
            if (r_k == K_W'(j)) begin
                cur_row = r_matrix[j];
            end
        end
        for (int j = 0; j < OUT; j++) begin
            if (r_pidx == IDX_W'(j)) begin
                row_bit = cur_row[j];
            end
        end
    end

    // Cap is one above the highest slot so far, clipped to the trial limit
    always_comb begin
        hi_p1    = CNT_W'(r_hi) + CNT_W'(1);
        cap      = (hi_p1 < r_limit) ? hi_p1 : r_limit;
        over_cap = (r_c > cap);
        used     = 1'b0;
        for (int j = 0; j < NUM_SUBJECTS; j++) begin
            if (r_c == CNT_W'(j + 1) && r_mask[j]) begin
                used = 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_command == CMD_SCHED) begin
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                if (r_i == K_W'(NUM_SUBJECTS - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: n_state = S_SCAN;
            S_SCAN: begin
                if (r_i >= r_k) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (over_cap) begin
                    n_state = S_LOAD;
                end else if (!used) begin
                    n_state = (r_k == K_W'(NUM_SUBJECTS - 1)) ? S_EMIT : S_LOAD;
                end
            end
            S_EMIT: begin
                if (r_i >= K_W'(OUT)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_matrix  = r_matrix;
        n_k       = r_k;
        n_i       = r_i;
        n_limit   = r_limit;
        n_pv      = 1'b0;
        n_pcur    = 1'b0;
        n_pidx    = r_pidx;
        n_c       = r_c;
        n_hi      = r_hi;
        n_mask    = r_mask;
        ram_we    = 1'b0;
        ram_waddr = r_k[IDX_W-1:0];
        ram_wdata = '0;
        ram_raddr = r_i[IDX_W-1:0];

        // Consume the read issued last cycle
        if (r_pv) begin
            if (r_pcur) begin
                n_c = CNT_W'(ram_rdata) + CNT_W'(1);
            end else if (r_state == S_SCAN) begin
                if (ram_rdata > r_hi) begin
                    n_hi = ram_rdata;
                end
                if (row_bit) begin
                    for (int j = 0; j < NUM_SUBJECTS; j++) begin
                        if (CNT_W'(ram_rdata) == CNT_W'(j + 1)) begin
                            n_mask[j] = 1'b1;
                        end
                    end
                end
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept && i_command == CMD_ADD) begin
                    for (int j = 0; j < OUT; j++) begin
                        for (int q = 0; q < OUT; q++) begin
                            if (pair_hit(j, q, i_subject_a, i_subject_b) ||
                                pair_hit(j, q, i_subject_a, i_subject_c) ||
                                pair_hit(j, q, i_subject_b, i_subject_c)) begin
                                n_matrix[j][q] = 1'b1;
                            end
                        end
                    end
                end else if (accept) begin
                    n_i = '0;
                end
            end
            S_CLR: begin
                // zero the slot RAM, then start with one slot at position 0
                ram_we    = 1'b1;
                ram_waddr = r_i[IDX_W-1:0];
                n_i       = r_i + K_W'(1);
                if (r_i == K_W'(NUM_SUBJECTS - 1)) begin
                    n_k     = '0;
                    n_limit = CNT_W'(1);
                end
            end
            S_LOAD: begin
                ram_raddr = r_k[IDX_W-1:0];
                n_pv      = 1'b1;
                n_pcur    = 1'b1;
                n_i       = '0;
                n_hi      = '0;
                n_mask    = '0;
            end
            S_SCAN: begin
                if (r_i < r_k) begin
                    ram_raddr = r_i[IDX_W-1:0];
                    n_pv      = 1'b1;
                    n_pidx    = r_i[IDX_W-1:0];
                    n_i       = r_i + K_W'(1);
                end
            end
            S_PICK: begin
                if (over_cap) begin
                    // drop this position and back up, or widen the trial
                    ram_we = 1'b1;
                    if (r_k == '0) begin
                        n_limit = r_limit + CNT_W'(1);
                    end else begin
                        n_k = r_k - K_W'(1);
                    end
                end else if (used) begin
                    n_c = r_c + CNT_W'(1);
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = r_c[SLOT_W-1:0];
                    n_i       = '0;
                    if (r_k != K_W'(NUM_SUBJECTS - 1)) begin
                        n_k = r_k + K_W'(1);
                    end
                end
            end
            S_EMIT: begin
                if (r_i < K_W'(OUT)) begin
                    ram_raddr = r_i[IDX_W-1:0];
                    n_pv      = 1'b1;
                    n_pidx    = r_i[IDX_W-1:0];
                    n_i       = r_i + K_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_limit <= CNT_W'(1);
            r_pv    <= 1'b0;
            for (int j = 0; j < OUT; j++) begin
                r_matrix[j] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_i      <= n_i;
            r_limit  <= n_limit;
            r_pv     <= n_pv;
            r_matrix <= n_matrix;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pcur <= n_pcur;
        r_pidx <= n_pidx;
        r_c    <= n_c;
        r_hi   <= n_hi;
        r_mask <= n_mask;
    end

    // Result beat comes straight off the registered RAM read
    assign o_valid      = (r_state == S_EMIT) && r_pv;
    assign o_subject    = CODE_W'(r_pidx);
    assign o_slot       = ram_rdata;
    assign o_slot_count = r_limit[SLOT_W-1:0];
    assign o_last       = (r_pidx == IDX_W'(OUT - 1));

    `CGSC_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_valid && o_last, !busy, "busy after last beat")
    `CGSC_ASSERT_NOW(a_slot_range, i_clk, i_rst_n, o_valid, (o_slot != '0) && (o_slot <= o_slot_count), "slot out of range")
    `CGSC_ASSERT_NEXT(a_sched_busy, i_clk, i_rst_n, accept && (i_command == CMD_SCHED), busy, "schedule not started")
    `CGSC_ASSERT_NOW(a_limit_range, i_clk, i_rst_n, r_state == S_PICK, (r_limit != '0) && (r_limit <= CNT_W'(NUM_SUBJECTS)), "trial limit out of range")

endmodule
